### hdl/psch_pkg.sv
// psch_pkg: shared widths, constants and types for the priority scheduler
// used by psch_cell and nonpreemptive_priority_scheduler_unit, no dependencies
`default_nettype none

package psch_pkg;

    localparam int MAX_PROCS_DEF = 64;

    localparam int ARR_W    = 16;
    localparam int BST_W    = 16;
    localparam int PRI_W    = 8;
    localparam int TIME_W   = 24;
    localparam int NUM_W    = 7;
    // wide enough for job numbers up to 1024
    localparam int JOB_ID_W = 11;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_WAIT,
        S_CALC,
        S_TAT,
        S_EMIT
    } state_t;

    // one stored job
    typedef struct packed {
        logic                vld;
        logic [ARR_W-1:0]    arr;
        logic [BST_W-1:0]    bst;
        logic [PRI_W-1:0]    pri;
        logic [JOB_ID_W-1:0] id;
    } job_t;

    // best job seen so far by a scan
    typedef struct packed {
        logic                found;
        logic [PRI_W-1:0]    pri;
        logic [ARR_W-1:0]    arr;
        logic [BST_W-1:0]    bst;
        logic [JOB_ID_W-1:0] id;
    } sel_t;

    // scan token moving along the row of cells
    typedef struct packed {
        logic tok;
        sel_t rdy;   // best among arrived jobs
        sel_t erl;   // best among earliest-arriving unfinished jobs
    } cand_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                shift;
        logic                clr;
        logic [JOB_ID_W-1:0] clr_id;
        logic [TIME_W-1:0]   clock_now;
    } ctl_t;

endpackage

`default_nettype wire

### hdl/psch_cell.sv
// psch_cell: one job slot of the scheduler row, holds a job and updates the
// passing scan token with a registered compare; depends on psch_pkg
`default_nettype none

module psch_cell (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  psch_pkg::ctl_t        ctl,
    input  psch_pkg::job_t        job_in,
    output psch_pkg::job_t        job_out,
    input  psch_pkg::cand_t       cand_in,
    output psch_pkg::cand_t       cand_out
);

    logic                            vld_reg;
    logic [psch_pkg::ARR_W-1:0]      arr_reg;
    logic [psch_pkg::BST_W-1:0]      bst_reg;
    logic [psch_pkg::PRI_W-1:0]      pri_reg;
    logic [psch_pkg::JOB_ID_W-1:0]   id_reg;

    psch_pkg::cand_t cand_reg;
    psch_pkg::cand_t cand_next;

    logic is_ready;
    logic rdy_better;
    logic erl_better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl.shift) begin
            vld_reg <= job_in.vld;
        end else if (ctl.clr && (id_reg == ctl.clr_id)) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            arr_reg <= job_in.arr;
            bst_reg <= job_in.bst;
            pri_reg <= job_in.pri;
            id_reg  <= job_in.id;
        end
    end

    assign job_out.vld = vld_reg;
    assign job_out.arr = arr_reg;
    assign job_out.bst = bst_reg;
    assign job_out.pri = pri_reg;
    assign job_out.id  = id_reg;

    assign is_ready = vld_reg
        && ({{(psch_pkg::TIME_W-psch_pkg::ARR_W){1'b0}}, arr_reg} <= ctl.clock_now);

    // higher priority, then earlier arrival, then lower job number
    assign rdy_better = is_ready && (!cand_in.rdy.found
        || (pri_reg > cand_in.rdy.pri)
        || ((pri_reg == cand_in.rdy.pri) && ((arr_reg < cand_in.rdy.arr)
            || ((arr_reg == cand_in.rdy.arr) && (id_reg < cand_in.rdy.id)))));

    // earliest arrival first, then as above among equal arrivals
    assign erl_better = vld_reg && (!cand_in.erl.found
        || (arr_reg < cand_in.erl.arr)
        || ((arr_reg == cand_in.erl.arr) && ((pri_reg > cand_in.erl.pri)
            || ((pri_reg == cand_in.erl.pri) && (id_reg < cand_in.erl.id)))));

    always_comb begin
        cand_next = cand_in;
        if (rdy_better) begin
            cand_next.rdy.found = 1'b1;
            cand_next.rdy.pri   = pri_reg;
            cand_next.rdy.arr   = arr_reg;
            cand_next.rdy.bst   = bst_reg;
            cand_next.rdy.id    = id_reg;
        end
        if (erl_better) begin
            cand_next.erl.found = 1'b1;
            cand_next.erl.pri   = pri_reg;
            cand_next.erl.arr   = arr_reg;
            cand_next.erl.bst   = bst_reg;
            cand_next.erl.id    = id_reg;
        end
    end

    // only the token bit needs a reset, the candidate data travels with it
    always_ff @(posedge aclk) begin
        cand_reg.rdy <= cand_next.rdy;
        cand_reg.erl <= cand_next.erl;
        if (!aresetn) begin
            cand_reg.tok <= 1'b0;
        end else begin
            cand_reg.tok <= cand_next.tok;
        end
    end

    assign cand_out = cand_reg;

endmodule

`default_nettype wire

### hdl/nonpreemptive_priority_scheduler_unit.sv
// nonpreemptive_priority_scheduler_unit: top level, load sequencer, result
// arithmetic and output register around a row of psch_cell; uses psch_pkg
//
// Usage: jobs come in on the s_ channel, one item per cycle while s_tready is
// high. s_tdata carries arrival, burst and priority; s_tlast marks the last
// job of a set. Jobs past MAX_PROCS are dropped. After the last job the block
// drops s_tready and schedules the set by non-preemptive priority, starting
// at time 0, and sends one result item per job on the m_ channel in execution
// order; m_tlast is high on the final result. Then it takes a new set.
// For each result, the START state launches a scan token, which walks the row
// of job cells one cell per cycle to find the next job, then completion,
// turnaround and waiting time take one registered step each. The result
// sits in an output register; when m_tready is low the block holds the next
// result until that register is taken, and a new set can be loaded while
// the final result still waits.
// Reset (aresetn low, synchronous) empties all cells and returns to loading.
`default_nettype none

module nonpreemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = psch_pkg::MAX_PROCS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
    input  wire  [psch_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // job_number[6:0], completion_time[30:7], turnaround_time[54:31],
    // waiting_time[78:55], zero[79]
    output logic [psch_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TW = psch_pkg::TIME_W;

    psch_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  rem_reg;
    logic [TW-1:0]  clock_reg;
    logic [TW-1:0]  comp_reg;
    logic [TW-1:0]  tat_reg;
    psch_pkg::sel_t win_reg;

    logic                          m_tvalid_reg;
    logic [psch_pkg::NUM_W-1:0]    out_num_reg;
    logic [TW-1:0]                 out_comp_reg;
    logic [TW-1:0]                 out_tat_reg;
    logic [TW-1:0]                 out_wait_reg;
    logic                          out_last_reg;

    logic s_accept;
    logic has_room;
    logic out_free;
    logic inject;
    logic do_shift;
    logic do_clr;
    logic [CW-1:0] count_after;
    logic [TW:0]   comp_sum;
    logic [TW-1:0] comp_sat;
    logic [TW-1:0] bst_ext;
    logic [TW-1:0] wait_val;

    psch_pkg::ctl_t  ctl;
    psch_pkg::job_t  job_chain  [0:MAX_PROCS];
    psch_pkg::cand_t cand_chain [0:MAX_PROCS];
    logic [MAX_PROCS-1:0] tok_vec;

    assign s_accept    = s_tvalid && s_tready;
    assign has_room    = (count_reg < CW'(MAX_PROCS));
    assign count_after = has_room ? (count_reg + CW'(1)) : count_reg;
    assign out_free    = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psch_pkg::S_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = psch_pkg::S_START;
                end
            end
            psch_pkg::S_START: begin
                state_next = psch_pkg::S_WAIT;
            end
            psch_pkg::S_WAIT: begin
                if (cand_chain[MAX_PROCS].tok) begin
                    state_next = psch_pkg::S_CALC;
                end
            end
            psch_pkg::S_CALC: begin
                state_next = psch_pkg::S_TAT;
            end
            psch_pkg::S_TAT: begin
                state_next = psch_pkg::S_EMIT;
            end
            psch_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = (rem_reg == CW'(1)) ? psch_pkg::S_LOAD
                                                     : psch_pkg::S_START;
                end
            end
            default: begin
                state_next = psch_pkg::S_LOAD;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        inject   = 1'b0;
        do_clr   = 1'b0;
        case (state_reg)
            psch_pkg::S_LOAD:  s_tready = 1'b1;
            psch_pkg::S_START: inject   = 1'b1;
            psch_pkg::S_CALC:  do_clr   = 1'b1;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign do_shift = s_accept && has_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psch_pkg::S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // row of job cells
    assign ctl.shift     = do_shift;
    assign ctl.clr       = do_clr;
    assign ctl.clr_id    = win_reg.id;
    assign ctl.clock_now = clock_reg;

    assign job_chain[0].vld = 1'b1;
    assign job_chain[0].arr = s_tdata[15:0];
    assign job_chain[0].bst = s_tdata[31:16];
    assign job_chain[0].pri = s_tdata[39:32];
    assign job_chain[0].id  = psch_pkg::JOB_ID_W'(count_reg) + psch_pkg::JOB_ID_W'(1);

    always_comb begin
        cand_chain[0]     = '0;
        cand_chain[0].tok = inject;
    end

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        psch_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .job_in   (job_chain[i]),
            .job_out  (job_chain[i+1]),
            .cand_in  (cand_chain[i]),
            .cand_out (cand_chain[i+1])
        );
        assign tok_vec[i] = cand_chain[i+1].tok;
    end

    // result arithmetic
    assign bst_ext  = TW'(win_reg.bst);
    assign comp_sum = {1'b0, clock_reg} + {1'b0, bst_ext};
    assign comp_sat = comp_sum[TW] ? psch_pkg::TIME_MAX : comp_sum[TW-1:0];
    assign wait_val = (tat_reg >= bst_ext) ? (tat_reg - bst_ext) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rem_reg   <= '0;
            clock_reg <= '0;
        end else begin
            case (state_reg)
                psch_pkg::S_LOAD: begin
                    if (s_accept) begin
                        count_reg <= count_after;
                        if (s_tlast) begin
                            rem_reg   <= count_after;
                            clock_reg <= '0;
                        end
                    end
                end
                psch_pkg::S_WAIT: begin
                    // nothing arrived yet: jump to the earliest arrival
                    if (cand_chain[MAX_PROCS].tok && !cand_chain[MAX_PROCS].rdy.found) begin
                        clock_reg <= TW'(cand_chain[MAX_PROCS].erl.arr);
                    end
                end
                psch_pkg::S_CALC: begin
                    clock_reg <= comp_sat;
                end
                psch_pkg::S_EMIT: begin
                    if (out_free) begin
                        rem_reg <= rem_reg - CW'(1);
                        if (rem_reg == CW'(1)) begin
                            count_reg <= '0;
                            clock_reg <= '0;
                        end
                    end
                end
                default: begin
                    rem_reg <= rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == psch_pkg::S_WAIT) && cand_chain[MAX_PROCS].tok) begin
            win_reg <= cand_chain[MAX_PROCS].rdy.found ? cand_chain[MAX_PROCS].rdy
                                                       : cand_chain[MAX_PROCS].erl;
        end
        if (state_reg == psch_pkg::S_CALC) begin
            comp_reg <= comp_sat;
        end
        if (state_reg == psch_pkg::S_TAT) begin
            tat_reg <= comp_reg - TW'(win_reg.arr);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == psch_pkg::S_EMIT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == psch_pkg::S_EMIT) && out_free) begin
            out_num_reg  <= psch_pkg::NUM_W'(win_reg.id);
            out_comp_reg <= comp_reg;
            out_tat_reg  <= tat_reg;
            out_wait_reg <= wait_val;
            out_last_reg <= (rem_reg == CW'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_wait_reg, out_tat_reg, out_comp_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

    // at most one scan token in the row
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one scan token in the cell row");

    // a finished scan always finds an unfinished job
    a_scan_finds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psch_pkg::S_WAIT) && cand_chain[MAX_PROCS].tok
        |-> cand_chain[MAX_PROCS].erl.found)
        else $error("scan ended without any unfinished job");

    // results are only produced while jobs remain
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psch_pkg::S_EMIT) |-> (rem_reg != '0))
        else $error("result emitted with no job remaining");

    // the far end of the row only holds a job once the store is full
    a_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psch_pkg::S_LOAD) && (count_reg < CW'(MAX_PROCS))
        |-> !job_chain[MAX_PROCS].vld)
        else $error("last cell holds a job while the store is not full");

endmodule

`default_nettype wire
